// File: rtl/homf_pkg.sv
package homf_pkg;

  localparam int PIX_W      = 8;
  localparam int MODE_W     = 3;
  localparam int MASK_W     = 9;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int WIN_N      = 9;
  localparam int CENTER     = 4;
  localparam int N_KERNELS  = 4;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // output queue entries; also bounds items in flight
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [PIX_W-1:0]              pix_t;
  typedef logic [MASK_W-1:0]             mask_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0]   win_t;

  localparam pix_t PIX_MAX = 8'hFF;
  localparam win_t WIN_BORDER = {WIN_N{PIX_MAX}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 3'd0,
    REG_HIT_MASK  = 3'd1,
    REG_MISS_MASK = 3'd2,
    REG_WIDTH     = 3'd3,
    REG_HEIGHT    = 3'd4
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_CUSTOM   = 3'd0,
    MODE_NOISE    = 3'd1,
    MODE_CORNER   = 3'd2,
    MODE_STRAIGHT = 3'd3,
    MODE_OUTLINE  = 3'd4
  } mode_e;

  localparam logic [MODE_W-1:0] MODE_RST      = MODE_OUTLINE;
  localparam mask_t             HIT_MASK_RST  = 9'h010;
  localparam mask_t             MISS_MASK_RST = 9'h000;
  localparam logic [DIM_W-1:0]  WIDTH_RST     = 11'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RST    = 11'd480;

  // bit i = window position i, row-major, bit 0 top-left
  localparam mask_t CORNER_HIT    [N_KERNELS] = '{9'h0B0, 9'h098, 9'h032, 9'h01A};
  localparam mask_t CORNER_MISS   [N_KERNELS] = '{9'h00B, 9'h026, 9'h0C8, 9'h1A0};
  localparam mask_t STRAIGHT_HIT  [N_KERNELS] = '{9'h038, 9'h092, 9'h038, 9'h092};
  localparam mask_t STRAIGHT_MISS [N_KERNELS] = '{9'h007, 9'h124, 9'h1C0, 9'h049};
  localparam mask_t NOISE_HIT  = 9'h010;
  localparam mask_t NOISE_MISS = 9'h0AA;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    mask_t             hit_mask;
    mask_t             miss_mask;
  } kcfg_t;

  typedef struct packed {
    pix_t result_pixel;
    logic frame_end;
  } res_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  // min over the selected positions, 255 when none is selected
  function automatic pix_t masked_min(win_t vals, mask_t sel);
    win_t t;
    pix_t l1a, l1b, l1c, l1d, l2a, l2b, l3;
    for (int i = 0; i < WIN_N; i++) begin
      t[i] = sel[i] ? vals[i] : PIX_MAX;
    end
    l1a = min2(t[0], t[1]);
    l1b = min2(t[2], t[3]);
    l1c = min2(t[4], t[5]);
    l1d = min2(t[6], t[7]);
    l2a = min2(l1a, l1b);
    l2b = min2(l1c, l1d);
    l3  = min2(l2a, l2b);
    return min2(l3, t[8]);
  endfunction

  function automatic pix_t hom(win_t hv, win_t mv, mask_t hm, mask_t mm);
    return masked_min(hv, hm) & masked_min(mv, mm);
  endfunction

  // shift window left by one column, new column enters on the right
  function automatic win_t win_shift(win_t w, pix_t t, pix_t m, pix_t b);
    win_t r;
    r = w;
    r[0] = w[1]; r[1] = w[2]; r[2] = t;
    r[3] = w[4]; r[4] = w[5]; r[5] = m;
    r[6] = w[7]; r[7] = w[8]; r[8] = b;
    return r;
  endfunction

endpackage

// File: rtl/homf_line_mem.sv
module homf_line_mem #(
  parameter int DEPTH = homf_pkg::MAX_WIDTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output homf_pkg::pix_t       rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  homf_pkg::pix_t       wr_data_i
);

  homf_pkg::pix_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// File: rtl/homf_kernel_eval.sv
module homf_kernel_eval (
  input  homf_pkg::win_t  win_i,
  input  homf_pkg::mask_t border_i,
  input  homf_pkg::kcfg_t kcfg_i,
  output homf_pkg::pix_t  result_o
);

  homf_pkg::win_t hit_v, miss_v;
  homf_pkg::pix_t custom_r, noise_r, corner_r, straight_r;

  // out-of-frame positions read as 255 in both terms
  always_comb begin
    for (int i = 0; i < homf_pkg::WIN_N; i++) begin
      hit_v[i]  = border_i[i] ? homf_pkg::PIX_MAX : win_i[i];
      miss_v[i] = border_i[i] ? homf_pkg::PIX_MAX : ~win_i[i];
    end
  end

  assign custom_r = homf_pkg::hom(hit_v, miss_v, kcfg_i.hit_mask, kcfg_i.miss_mask);
  assign noise_r  = win_i[homf_pkg::CENTER]
                  ^ homf_pkg::hom(hit_v, miss_v, homf_pkg::NOISE_HIT, homf_pkg::NOISE_MISS);

  always_comb begin
    corner_r   = '0;
    straight_r = '0;
    for (int k = 0; k < homf_pkg::N_KERNELS; k++) begin
      corner_r   = corner_r | homf_pkg::hom(hit_v, miss_v, homf_pkg::CORNER_HIT[k],
                                             homf_pkg::CORNER_MISS[k]);
      straight_r = straight_r | homf_pkg::hom(hit_v, miss_v, homf_pkg::STRAIGHT_HIT[k],
                                               homf_pkg::STRAIGHT_MISS[k]);
    end
  end

  always_comb begin
    case (kcfg_i.mode)
      homf_pkg::MODE_CUSTOM:   result_o = custom_r;
      homf_pkg::MODE_NOISE:    result_o = noise_r;
      homf_pkg::MODE_CORNER:   result_o = corner_r;
      homf_pkg::MODE_STRAIGHT: result_o = straight_r;
      default:                 result_o = corner_r | straight_r;
    endcase
  end

endmodule

// File: rtl/homf_out_queue.sv
module homf_out_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  homf_pkg::res_t                push_data_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output homf_pkg::res_t                data_o,
  output logic [homf_pkg::QCNT_W-1:0]   count_o
);

  localparam int PW = homf_pkg::QPTR_W;
  localparam int CNW = homf_pkg::QCNT_W;

  homf_pkg::res_t entries [homf_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNW-1:0] cnt_q;
  logic           do_pop;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(homf_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign data_o  = entries[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      cnt_q <= cnt_q + CNW'(push_i) - CNW'(do_pop);
    end
  end

endmodule

// File: rtl/hit_or_miss_outline_filter_unit.sv
// 3x3 hit-or-miss outline filter, 8-bit pixels in raster order.
// Input channel: in_valid_i / in_stall_o with pixel_i and padding_i; one
// pixel per beat. Padding beats (or any beat past the last row) count as
// 255 and flush the window; a WxH frame needs W+1 extra beats.
// Output channel: out_valid_o / out_stall_i with result_pixel_o and
// frame_end_o; one result per centre pixel, raster order, frame_end_o set
// on the last one. Results trail the input by one row and one pixel.
// Config channel: cfg_valid_i / cfg_ready_o (always ready), index and data;
// write only while the filter is idle.
// Throughput: one beat per cycle while in_stall_o is low. Each beat passes a
// counter/read stage, a line store read-modify-write stage and a kernel
// stage, and its result, if it has one, is written into the output queue.
// The line stores are two single-port-write, one-read RAMs of MAX_WIDTH
// entries; back-to-back hits on one column are forwarded.
// A four-entry output queue decouples the sides: in_stall_o rises once the
// queue and the two inner stages hold four beats, so a stalled receiver
// backs up the input only after that.
// Reset clears counters, window and queue and sets the config to its defaults;
// line store contents stay undefined and are never used before being written.
module hit_or_miss_outline_filter_unit #(
  parameter int MAX_WIDTH  = homf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = homf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [homf_pkg::PIX_W-1:0]         pixel_i,
  input  logic                               padding_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [homf_pkg::PIX_W-1:0]         result_pixel_o,
  output logic                               frame_end_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [homf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [homf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 3);
  localparam int DW  = homf_pkg::DIM_W;
  localparam int WXW = (CW > DW) ? CW : DW;
  localparam int HXW = (RW > DW) ? RW : DW;
  localparam int QW  = homf_pkg::QCNT_W;

  typedef struct packed {
    homf_pkg::pix_t  v;
    logic [AW-1:0]   addr;
    logic            top_ok;
    logic            mid_ok;
    logic            c0;
    logic            last;
    logic            restart;
    logic            has_out;
    logic            fwd;
    homf_pkg::mask_t border;
  } rd_stage_t;

  typedef struct packed {
    logic            last;
    homf_pkg::mask_t border;
    homf_pkg::win_t  fw;
  } ev_stage_t;

  // configuration
  logic [homf_pkg::MODE_W-1:0] mode_q;
  homf_pkg::mask_t             hit_mask_q, miss_mask_q;
  logic [DW-1:0]               width_q, height_q;
  homf_pkg::kcfg_t             kcfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= homf_pkg::MODE_RST;
      hit_mask_q  <= homf_pkg::HIT_MASK_RST;
      miss_mask_q <= homf_pkg::MISS_MASK_RST;
      width_q     <= homf_pkg::WIDTH_RST;
      height_q    <= homf_pkg::HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        homf_pkg::REG_MODE:      mode_q      <= cfg_data_i[homf_pkg::MODE_W-1:0];
        homf_pkg::REG_HIT_MASK:  hit_mask_q  <= cfg_data_i[homf_pkg::MASK_W-1:0];
        homf_pkg::REG_MISS_MASK: miss_mask_q <= cfg_data_i[homf_pkg::MASK_W-1:0];
        homf_pkg::REG_WIDTH:     width_q     <= cfg_data_i[DW-1:0];
        homf_pkg::REG_HEIGHT:    height_q    <= cfg_data_i[DW-1:0];
        default: ;
      endcase
    end
  end

  assign kcfg = '{mode: mode_q, hit_mask: hit_mask_q, miss_mask: miss_mask_q};

  // clamped frame size
  logic [WXW-1:0] width_x;
  logic [HXW-1:0] height_x;
  logic [CW-1:0]  width_c;
  logic [RW-1:0]  height_c, h_p1, h_p2;

  assign width_x  = WXW'(width_q);
  assign height_x = HXW'(height_q);

  always_comb begin
    if (width_x < WXW'(3))              width_c = CW'(3);
    else if (width_x > WXW'(MAX_WIDTH)) width_c = CW'(MAX_WIDTH);
    else                                width_c = width_x[CW-1:0];
    if (height_x < HXW'(3))               height_c = RW'(3);
    else if (height_x > HXW'(MAX_HEIGHT)) height_c = RW'(MAX_HEIGHT);
    else                                  height_c = height_x[RW-1:0];
  end

  assign h_p1 = height_c + RW'(1);
  assign h_p2 = height_c + RW'(2);

  // stage 0: position of the incoming beat, line store read
  logic [CW-1:0] col_q, col_d, col_w, c0_col;
  logic [RW-1:0] row_q, row_d, row_w, r0;
  logic          accept, wrap, restart, c0, last0, has_out0;
  logic          top_b, bot_b, left_b, right_b;
  homf_pkg::mask_t border0;
  homf_pkg::pix_t  v0;
  logic [AW-1:0]   addr0;

  rd_stage_t s1_q, s1_d;
  logic      s1_valid_q;
  ev_stage_t s2_q, s2_d;
  logic      s2_valid_q;

  logic [QW-1:0] q_count;
  logic [QW:0]   in_flight;

  assign in_flight  = {1'b0, q_count} + (QW+1)'(s1_valid_q) + (QW+1)'(s2_valid_q);
  assign in_stall_o = (in_flight >= (QW+1)'(homf_pkg::QUEUE_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    wrap    = (col_q >= width_c);
    col_w   = wrap ? '0 : col_q;
    row_w   = wrap ? row_q + RW'(1) : row_q;
    restart = (row_w > h_p1);
    r0      = restart ? '0 : row_w;
    c0_col  = restart ? '0 : col_w;
    c0      = (c0_col == '0);
    addr0   = c0_col[AW-1:0];
    v0      = (padding_i || (r0 >= height_c)) ? homf_pkg::PIX_MAX : pixel_i;
    last0   = c0 && (r0 == h_p1);
    has_out0 = c0 ? (r0 >= RW'(2)) : ((r0 >= RW'(1)) && (r0 <= height_c));
    // centre is (r-2, w-1) on column 0, else (r-1, c-1)
    top_b   = c0 ? (r0 == RW'(2)) : (r0 == RW'(1));
    bot_b   = c0 ? last0 : (r0 == height_c);
    left_b  = !c0 && (c0_col == CW'(1));
    right_b = c0;
    border0 = {bot_b | right_b, bot_b, bot_b | left_b,
               right_b, 1'b0, left_b,
               top_b | right_b, top_b, top_b | left_b};

    s1_d.v       = v0;
    s1_d.addr    = addr0;
    s1_d.top_ok  = (r0 >= RW'(2)) && (r0 < h_p2);
    s1_d.mid_ok  = (r0 >= RW'(1)) && (r0 <= height_c);
    s1_d.c0      = c0;
    s1_d.last    = last0;
    s1_d.restart = restart;
    s1_d.has_out = has_out0;
    s1_d.fwd     = s1_valid_q && (s1_q.addr == addr0);
    s1_d.border  = border0;

    if (last0) begin
      col_d = '0;
      row_d = '0;
    end else begin
      col_d = c0_col + CW'(1);
      row_d = r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  // stage 1: line store read-modify-write, window update
  homf_pkg::pix_t rd_a, rd_b, rda, rdb, top_px, mid_px, wa_q, wb_q;
  homf_pkg::win_t window_q, window_d, w0, w1, w2;

  homf_line_mem #(.DEPTH(MAX_WIDTH)) u_line_a (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (addr0),
    .rd_data_o (rd_a),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_q.addr),
    .wr_data_i (s1_q.v)
  );

  homf_line_mem #(.DEPTH(MAX_WIDTH)) u_line_b (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (addr0),
    .rd_data_o (rd_b),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_q.addr),
    .wr_data_i (rda)
  );

  always_comb begin
    // same column written last cycle: take the values just stored
    rda    = s1_q.fwd ? wa_q : rd_a;
    rdb    = s1_q.fwd ? wb_q : rd_b;
    top_px = s1_q.top_ok ? rdb : homf_pkg::PIX_MAX;
    mid_px = s1_q.mid_ok ? rda : homf_pkg::PIX_MAX;
    w0     = s1_q.restart ? homf_pkg::WIN_BORDER : window_q;
    w1     = s1_q.c0 ? homf_pkg::win_shift(w0, homf_pkg::PIX_MAX, homf_pkg::PIX_MAX,
                                           homf_pkg::PIX_MAX) : w0;
    w2     = homf_pkg::win_shift(w1, top_px, mid_px, s1_q.v);
    window_d = s1_q.last ? homf_pkg::WIN_BORDER : w2;
    s2_d.last   = s1_q.last;
    s2_d.border = s1_q.border;
    s2_d.fw     = s1_q.c0 ? w1 : w2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= homf_pkg::WIN_BORDER;
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q && s1_q.has_out;
      if (s1_valid_q) begin
        window_q <= window_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      wa_q <= s1_q.v;
      wb_q <= rda;
      s2_q <= s2_d;
    end
  end

  // stage 2: kernels, into the output queue
  homf_pkg::pix_t kernel_res;
  homf_pkg::res_t push_data, head;

  homf_kernel_eval u_kernel (
    .win_i    (s2_q.fw),
    .border_i (s2_q.border),
    .kcfg_i   (kcfg),
    .result_o (kernel_res)
  );

  assign push_data = '{result_pixel: kernel_res, frame_end: s2_q.last};

  homf_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_valid_q),
    .push_data_i (push_data),
    .pop_i       (!out_stall_i),
    .valid_o     (out_valid_o),
    .data_o      (head),
    .count_o     (q_count)
  );

  assign result_pixel_o = head.result_pixel;
  assign frame_end_o    = head.frame_end;

endmodule

// File: rtl/homf_checker.sv
module homf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [homf_pkg::PIX_W-1:0]      result_pixel_o,
  input logic                            frame_end_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_pixel_o) && $stable(frame_end_o))
    else $error("output beat changed under stall");

  // an empty output side always leaves room for input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output queue");

  // a rising output valid goes back to an input beat through the inner stages and the queue
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_beat, 3))
    else $error("result appeared without a beat three cycles earlier");

endmodule

bind hit_or_miss_outline_filter_unit homf_checker u_checker (.*);

// File: tb/sv/hit_or_miss_outline_filter_unit_test.sv
module hit_or_miss_outline_filter_unit_test;
  import homf_pkg::*;

  localparam int LINE_MAX = 1024;
  localparam int ROWS_MAX = 1024;
  localparam int IDLE_PCT = 31;
  localparam int DRAIN_LIMIT = 50000;

  // kernel positions, bit i = window position i, row-major from top-left
  localparam mask_t K_CORNER_HIT    [4] = '{9'h0B0, 9'h098, 9'h032, 9'h01A};
  localparam mask_t K_CORNER_MISS   [4] = '{9'h00B, 9'h026, 9'h0C8, 9'h1A0};
  localparam mask_t K_STRAIGHT_HIT  [4] = '{9'h038, 9'h092, 9'h038, 9'h092};
  localparam mask_t K_STRAIGHT_MISS [4] = '{9'h007, 9'h124, 9'h1C0, 9'h049};
  localparam mask_t K_SPECK_HIT  = 9'h010;
  localparam mask_t K_SPECK_MISS = 9'h0AA;

  typedef struct packed {
    pix_t px;
    logic pad;
  } beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [PIX_W-1:0]      pixel_i = '0;
  logic                  padding_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PIX_W-1:0]      result_pixel_o;
  logic                  frame_end_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  hit_or_miss_outline_filter_unit dut (.*);

  always #1 clk_i = ~clk_i;

  // filter state as seen from the pins
  logic [MODE_W-1:0] cfg_mode = MODE_OUTLINE;
  mask_t             cfg_hit = 9'h010;
  mask_t             cfg_miss = 9'h000;
  logic [DIM_W-1:0]  cfg_width = 11'd640;
  logic [DIM_W-1:0]  cfg_height = 11'd480;

  pix_t store_up  [LINE_MAX];
  pix_t store_mid [LINE_MAX];
  pix_t nbhd [9] = '{default: 8'hFF};
  int   col_at = 0;
  int   row_at = 0;

  beat_t feed_q [$];
  res_t  expected_px [$];
  res_t  want;
  bit    steady = 1'b0;

  int mismatches = 0;
  int beats_in = 0;
  int results_seen = 0;
  int frames_done = 0;
  int frame_ends_seen = 0;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  function automatic pix_t kernel_match(mask_t hm, mask_t mm, int cr, int cc, int w, int h);
    pix_t hv, mv, a, b;
    int   r, c;
    bit   in_frame;
    hv = 8'hFF;
    mv = 8'hFF;
    for (int i = 0; i < 9; i++) begin
      r = cr + i / 3 - 1;
      c = cc + i % 3 - 1;
      in_frame = r >= 0 && r < h && c >= 0 && c < w;
      a = in_frame ? nbhd[i] : 8'hFF;
      b = in_frame ? ~nbhd[i] : 8'hFF;
      if (hm[i] && a < hv) hv = a;
      if (mm[i] && b < mv) mv = b;
    end
    return hv & mv;
  endfunction

  function automatic pix_t filter_value(int cr, int cc, int w, int h);
    pix_t acc;
    acc = '0;
    case (cfg_mode)
      MODE_CUSTOM: return kernel_match(cfg_hit, cfg_miss, cr, cc, w, h);
      MODE_NOISE:  return nbhd[4] ^ kernel_match(K_SPECK_HIT, K_SPECK_MISS, cr, cc, w, h);
      default: begin
        if (cfg_mode != MODE_STRAIGHT)
          for (int k = 0; k < 4; k++)
            acc |= kernel_match(K_CORNER_HIT[k], K_CORNER_MISS[k], cr, cc, w, h);
        if (cfg_mode != MODE_CORNER)
          for (int k = 0; k < 4; k++)
            acc |= kernel_match(K_STRAIGHT_HIT[k], K_STRAIGHT_MISS[k], cr, cc, w, h);
        return acc;
      end
    endcase
  endfunction

  task automatic push_column(input pix_t t, input pix_t m, input pix_t b);
    nbhd[0] = nbhd[1]; nbhd[1] = nbhd[2]; nbhd[2] = t;
    nbhd[3] = nbhd[4]; nbhd[4] = nbhd[5]; nbhd[5] = m;
    nbhd[6] = nbhd[7]; nbhd[7] = nbhd[8]; nbhd[8] = b;
  endtask

  // advance the window by one accepted beat, queue the pixel it completes
  task automatic predict_beat(input pix_t px, input logic pad);
    int   w, h, r, c;
    pix_t v, top, mid;
    res_t res;
    w = cfg_width;
    h = cfg_height;
    if (w < 3) w = 3;
    if (w > LINE_MAX) w = LINE_MAX;
    if (h < 3) h = 3;
    if (h > ROWS_MAX) h = ROWS_MAX;
    if (col_at >= w) begin
      col_at = 0;
      row_at++;
    end
    if (row_at > h + 1) begin
      row_at = 0;
      col_at = 0;
      nbhd = '{default: 8'hFF};
    end
    r = row_at;
    c = col_at;
    v = (pad || r >= h) ? 8'hFF : px;
    top = (r >= 2 && r - 2 < h) ? store_up[c] : 8'hFF;
    mid = (r >= 1 && r - 1 < h) ? store_mid[c] : 8'hFF;
    store_up[c] = store_mid[c];
    store_mid[c] = v;
    if (c == 0) begin
      push_column(8'hFF, 8'hFF, 8'hFF);
      if (r >= 2) begin
        res.result_pixel = filter_value(r - 2, w - 1, w, h);
        res.frame_end = (r - 2 == h - 1);
        expected_px.push_back(res);
        if (res.frame_end) begin
          row_at = 0;
          col_at = 0;
          nbhd = '{default: 8'hFF};
          frames_done++;
          return;
        end
      end
      push_column(top, mid, v);
    end else begin
      push_column(top, mid, v);
      if (r >= 1 && r - 1 < h) begin
        res.result_pixel = filter_value(r - 1, c - 1, w, h);
        res.frame_end = 1'b0;
        expected_px.push_back(res);
      end
    end
    col_at++;
  endtask

  // pixel driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_beat(pixel_i, padding_i);
        beats_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (feed_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid_i <= 1'b1;
          {pixel_i, padding_i} <= feed_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_px.size() == 0) begin
          flag_mismatch($sformatf("result %0d: unexpected pixel %02h frame_end %b",
                                  results_seen, result_pixel_o, frame_end_o));
        end else begin
          want = expected_px.pop_front();
          if (result_pixel_o !== want.result_pixel)
            flag_mismatch($sformatf("result %0d: pixel %02h, expected %02h",
                                    results_seen, result_pixel_o, want.result_pixel));
          if (frame_end_o !== want.frame_end)
            flag_mismatch($sformatf("result %0d: frame_end %b, expected %b",
                                    results_seen, frame_end_o, want.frame_end));
        end
        if (frame_end_o === 1'b1) frame_ends_seen++;
        results_seen++;
      end
      out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MODE:      cfg_mode   = val[MODE_W-1:0];
      REG_HIT_MASK:  cfg_hit    = val[MASK_W-1:0];
      REG_MISS_MASK: cfg_miss   = val[MASK_W-1:0];
      REG_WIDTH:     cfg_width  = val[DIM_W-1:0];
      REG_HEIGHT:    cfg_height = val[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_filter(input int mode_v, input int hit_v, input int miss_v,
                                input int wreg, input int hreg);
    write_reg(REG_MODE, CFG_DATA_W'(mode_v));
    write_reg(REG_HIT_MASK, CFG_DATA_W'(hit_v));
    write_reg(REG_MISS_MASK, CFG_DATA_W'(miss_v));
    write_reg(REG_WIDTH, CFG_DATA_W'(wreg));
    write_reg(REG_HEIGHT, CFG_DATA_W'(hreg));
    cfg_valid_i <= 1'b0;
  endtask

  // all beats taken and all results back, then let the pipe settle
  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((feed_q.size() != 0 || in_valid_i || expected_px.size() != 0) &&
           guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push_beat(input pix_t px, input logic pad);
    beat_t b;
    b.px = px;
    b.pad = pad;
    feed_q.push_back(b);
  endtask

  // one frame plus its flush; binary frames let the kernels actually match
  task automatic queue_frame(input int wreg, input int hreg, output int n);
    int   w, h, dens;
    bit   gray;
    pix_t px;
    w = wreg < 3 ? 3 : (wreg > LINE_MAX ? LINE_MAX : wreg);
    h = hreg < 3 ? 3 : (hreg > ROWS_MAX ? ROWS_MAX : hreg);
    gray = ($urandom_range(3) == 0);
    dens = $urandom_range(10, 90);
    for (int i = 0; i < w * h; i++) begin
      if (gray || $urandom_range(19) == 0) px = pix_t'($urandom_range(255));
      else px = ($urandom_range(99) < dens) ? 8'hFF : 8'h00;
      push_beat(px, $urandom_range(99) < 3);
    end
    // anything past the last row is border, whatever it carries
    for (int i = 0; i <= w; i++) push_beat(pix_t'($urandom_range(255)), 1'($urandom_range(1)));
    n = w * h + w + 1;
  endtask

  function automatic int pick_mask();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 9'h1FF;
      default: return $urandom_range(511);
    endcase
  endfunction

  function automatic int pick_dim(input int hi);
    case ($urandom_range(9))
      0:       return $urandom_range(2);
      1:       return $urandom_range(hi + 1, 40);
      default: return $urandom_range(3, hi);
    endcase
  endfunction

  initial begin : stimulus
    int rand_beats, n, frame_no;
    rand_beats = 0;
    frame_no = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x3, all positions hit: plain erosion with extreme values and inner padding
    program_filter(MODE_CUSTOM, 9'h1FF, 9'h000, 3, 3);
    push_beat(8'h00, 1'b0); push_beat(8'hFF, 1'b0); push_beat(8'h01, 1'b0);
    push_beat(8'hFE, 1'b0); push_beat(8'h80, 1'b0); push_beat(8'h00, 1'b1);
    push_beat(8'h55, 1'b0); push_beat(8'hAA, 1'b0); push_beat(8'hFF, 1'b0);
    push_beat(8'h00, 1'b0); push_beat(8'hFF, 1'b1); push_beat(8'h7F, 1'b0);
    push_beat(8'hC3, 1'b1);
    wait_drained();

    // isolated bright speck under noise removal
    program_filter(MODE_NOISE, 9'h000, 9'h1FF, 3, 3);
    for (int i = 0; i < 9; i++) push_beat(i == 4 ? 8'hFF : 8'h00, 1'b0);
    for (int i = 0; i < 4; i++) push_beat(8'h00, 1'b1);
    wait_drained();

    // register values below the clamp limits
    program_filter($urandom_range(7), pick_mask(), pick_mask(), 2, 0);
    queue_frame(2, 0, n);
    wait_drained();
    program_filter(MODE_OUTLINE, pick_mask(), pick_mask(), 0, 2);
    queue_frame(0, 2, n);
    wait_drained();

    while (rand_beats < 1000) begin
      steady = (frame_no >= 8 && frame_no < 14);
      program_filter($urandom_range(7), pick_mask(), pick_mask(), pick_dim(12), pick_dim(8));
      queue_frame(cfg_width, cfg_height, n);
      rand_beats += n;
      frame_no++;
      wait_drained();
    end
    steady = 1'b0;

    repeat (10) @(posedge clk_i);
    if (expected_px.size() != 0)
      flag_mismatch($sformatf("%0d results never came out", expected_px.size()));
    $display("Filtered %0d frames: %0d pixel beats in, %0d results checked, %0d frame ends.",
             frames_done, beats_in, results_seen, frame_ends_seen);
    $display("All eight mode codes, empty and full masks, clamped sizes; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("hit_or_miss_outline_filter_unit_test OK");
    end else begin
      $display("hit_or_miss_outline_filter_unit_test NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("hit_or_miss_outline_filter_unit_test NOT OK");
    $finish;
  end

endmodule

// File: hit_or_miss_outline_filter_unit.f
rtl/homf_pkg.sv
rtl/homf_line_mem.sv
rtl/homf_kernel_eval.sv
rtl/homf_out_queue.sv
rtl/hit_or_miss_outline_filter_unit.sv
rtl/homf_checker.sv
tb/sv/hit_or_miss_outline_filter_unit_test.sv
